// ----- rtl/manchester_frame_receiver_assert.svh -----
// assertion macros for the manchester frame receiver
`ifndef MANCHESTER_FRAME_RECEIVER_ASSERT_SVH
`define MANCHESTER_FRAME_RECEIVER_ASSERT_SVH

// same-cycle implication, checked outside reset
`define MFR_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("manchester frame receiver: same-cycle check failed");

// next-cycle implication, checked outside reset
`define MFR_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("manchester frame receiver: next-cycle check failed");

`endif

// ----- rtl/mfr_pkg.sv -----
package mfr_pkg;

   // timer width and saturation value
   localparam int TIMER_WIDTH = 9;
   localparam logic [TIMER_WIDTH-1:0] TICK_MAX = {TIMER_WIDTH{1'b1}};

   typedef logic [TIMER_WIDTH-1:0] tick_type;

   // configuration register indexes
   typedef enum logic [1:0] {
      CSR_MIN_HALF  = 2'd0,
      CSR_MAX_HALF  = 2'd1,
      CSR_MAX_PRE   = 2'd2,
      CSR_UNUSED    = 2'd3
   } csr_index_type;

   // reset values of the configuration registers
   localparam logic [6:0] MIN_HALF_RESET = 7'd40;
   localparam logic [6:0] MAX_HALF_RESET = 7'd68;
   localparam logic [3:0] MAX_PRE_RESET  = 4'd8;

   // result status codes
   typedef enum logic [2:0] {
      ST_OK          = 3'd0,
      ST_SYNC_TMO    = 3'd1,
      ST_PERIOD_ERR  = 3'd2,
      ST_BIT_TIMING  = 3'd3,
      ST_PREAMBLE    = 3'd4
   } status_type;

   // receiver phases
   typedef enum logic [3:0] {
      PH_IDLE     = 4'd0,
      PH_S1_HI    = 4'd1,
      PH_S2_LO    = 4'd2,
      PH_S2_HI    = 4'd3,
      PH_S3_LO    = 4'd4,
      PH_S3_HI    = 4'd5,
      PH_S4_LO    = 4'd6,
      PH_PRE_WAIT = 4'd7,
      PH_PRE_EDGE = 4'd8,
      PH_ADR_WAIT = 4'd9,
      PH_ADR_EDGE = 4'd10,
      PH_DAT_WAIT = 4'd11,
      PH_DAT_EDGE = 4'd12
   } phase_type;

   // configuration set handed to the decoder
   typedef struct packed {
      logic [6:0] min_half;
      logic [6:0] max_half;
      logic [3:0] max_pre;
   } cfg_type;

   // one result transaction
   typedef struct packed {
      status_type status;
      logic [7:0] address;
      logic [7:0] payload;
   } result_type;

   // timer past its limit, or saturated
   function automatic logic timed_out(tick_type tick, tick_type limit);
      return (tick > limit) || (tick == TICK_MAX);
   endfunction

endpackage

// ----- rtl/mfr_decoder.sv -----
module mfr_decoder (
   input  logic                clock,
   input  logic                reset,
   input  logic                accept,
   input  logic                rx_level,
   input  mfr_pkg::cfg_type    cfg,
   output logic                result_valid,
   output mfr_pkg::result_type result
);

   mfr_pkg::phase_type phase_ff, phase_in;
   mfr_pkg::tick_type  tick_ff, tick_in;
   logic               last_ff, last_in;
   logic [7:0]         early_ff, early_in;
   logic [8:0]         late_ff, late_in;
   logic               held_ff, held_in;
   logic [3:0]         bidx_ff, bidx_in;
   logic [7:0]         addr_ff, addr_in;
   logic [7:0]         data_ff, data_in;

   mfr_pkg::tick_type  tick_inc;
   mfr_pkg::tick_type  lim_half;
   mfr_pkg::tick_type  lim_full;
   mfr_pkg::tick_type  lim_late;
   logic [7:0]         period;
   logic [7:0]         twice_min;
   logic [7:0]         twice_max;
   logic [4:0]         pre_next;
   logic [3:0]         bidx_inc;
   logic               bit_val;
   logic [7:0]         data_shifted;

   // saturating timer step and derived limits
   always_comb begin
      tick_inc     = (tick_ff == mfr_pkg::TICK_MAX) ? tick_ff : tick_ff + 1'b1;
      twice_max    = {cfg.max_half, 1'b0};
      twice_min    = {cfg.min_half, 1'b0};
      lim_half     = mfr_pkg::tick_type'(cfg.max_half);
      lim_full     = mfr_pkg::tick_type'(twice_max);
      lim_late     = mfr_pkg::tick_type'(late_ff);
      period       = tick_inc[7:0];
      pre_next     = {1'b0, bidx_ff} + 5'd1;
      bidx_inc     = bidx_ff + 4'd1;
      bit_val      = ~held_ff;
      data_shifted = {data_ff[6:0], bit_val};
   end

   // next state and result
   always_comb begin
      phase_in       = phase_ff;
      tick_in        = tick_ff;
      last_in        = last_ff;
      early_in       = early_ff;
      late_in        = late_ff;
      held_in        = held_ff;
      bidx_in        = bidx_ff;
      addr_in        = addr_ff;
      data_in        = data_ff;
      result_valid   = 1'b0;
      result.status  = mfr_pkg::ST_OK;
      result.address = 8'd0;
      result.payload = 8'd0;
      if (accept) begin
         last_in = rx_level;
         if (phase_ff != mfr_pkg::PH_IDLE) begin
            tick_in = tick_inc;
         end
         case (phase_ff)
            mfr_pkg::PH_S1_HI: begin
               if (!rx_level) begin
                  tick_in  = '0;
                  phase_in = mfr_pkg::PH_S2_LO;
               end else if (mfr_pkg::timed_out(tick_inc, lim_half)) begin
                  result_valid  = 1'b1;
                  result.status = mfr_pkg::ST_SYNC_TMO;
               end
            end
            mfr_pkg::PH_S2_LO, mfr_pkg::PH_S3_LO: begin
               if (rx_level) begin
                  phase_in = (phase_ff == mfr_pkg::PH_S2_LO) ? mfr_pkg::PH_S2_HI
                                                             : mfr_pkg::PH_S3_HI;
               end else if (mfr_pkg::timed_out(tick_inc, lim_half)) begin
                  result_valid  = 1'b1;
                  result.status = mfr_pkg::ST_SYNC_TMO;
               end
            end
            mfr_pkg::PH_S2_HI: begin
               if (!rx_level) begin
                  tick_in  = '0;
                  phase_in = mfr_pkg::PH_S3_LO;
               end else if (mfr_pkg::timed_out(tick_inc, lim_full)) begin
                  result_valid  = 1'b1;
                  result.status = mfr_pkg::ST_SYNC_TMO;
               end
            end
            mfr_pkg::PH_S3_HI: begin
               if (!rx_level) begin
                  // full symbol measured: range check and sample windows
                  tick_in = '0;
                  if (period < twice_min || period > twice_max) begin
                     result_valid  = 1'b1;
                     result.status = mfr_pkg::ST_PERIOD_ERR;
                  end else begin
                     early_in = period - {2'b00, period[7:2]};
                     late_in  = {1'b0, period} + {3'b000, period[7:2]};
                     phase_in = mfr_pkg::PH_S4_LO;
                  end
               end else if (mfr_pkg::timed_out(tick_inc, lim_full)) begin
                  result_valid  = 1'b1;
                  result.status = mfr_pkg::ST_SYNC_TMO;
               end
            end
            mfr_pkg::PH_S4_LO: begin
               if (rx_level) begin
                  tick_in  = '0;
                  bidx_in  = 4'd0;
                  phase_in = mfr_pkg::PH_PRE_WAIT;
               end else if (mfr_pkg::timed_out(tick_inc, lim_half)) begin
                  result_valid  = 1'b1;
                  result.status = mfr_pkg::ST_SYNC_TMO;
               end
            end
            mfr_pkg::PH_PRE_WAIT, mfr_pkg::PH_ADR_WAIT, mfr_pkg::PH_DAT_WAIT: begin
               // hold the level once the early window opens
               if (tick_inc >= mfr_pkg::tick_type'(early_ff)) begin
                  held_in = rx_level;
                  case (phase_ff)
                     mfr_pkg::PH_PRE_WAIT: phase_in = mfr_pkg::PH_PRE_EDGE;
                     mfr_pkg::PH_ADR_WAIT: phase_in = mfr_pkg::PH_ADR_EDGE;
                     default:              phase_in = mfr_pkg::PH_DAT_EDGE;
                  endcase
               end
            end
            mfr_pkg::PH_PRE_EDGE, mfr_pkg::PH_ADR_EDGE, mfr_pkg::PH_DAT_EDGE: begin
               if (rx_level == held_ff) begin
                  if (mfr_pkg::timed_out(tick_inc, lim_late)) begin
                     result_valid  = 1'b1;
                     result.status = mfr_pkg::ST_BIT_TIMING;
                  end
               end else begin
                  // mid-symbol transition decodes one bit
                  tick_in = '0;
                  case (phase_ff)
                     mfr_pkg::PH_PRE_EDGE: begin
                        if (!bit_val) begin
                           bidx_in  = 4'd0;
                           addr_in  = 8'd0;
                           phase_in = mfr_pkg::PH_ADR_WAIT;
                        end else if (pre_next > {1'b0, cfg.max_pre}) begin
                           result_valid  = 1'b1;
                           result.status = mfr_pkg::ST_PREAMBLE;
                        end else begin
                           bidx_in  = pre_next[3:0];
                           phase_in = mfr_pkg::PH_PRE_WAIT;
                        end
                     end
                     mfr_pkg::PH_ADR_EDGE: begin
                        addr_in = {addr_ff[6:0], bit_val};
                        if (bidx_inc >= 4'd8) begin
                           bidx_in  = 4'd0;
                           data_in  = 8'd0;
                           phase_in = mfr_pkg::PH_DAT_WAIT;
                        end else begin
                           bidx_in  = bidx_inc;
                           phase_in = mfr_pkg::PH_ADR_WAIT;
                        end
                     end
                     default: begin
                        data_in = data_shifted;
                        if (bidx_inc >= 4'd8) begin
                           bidx_in        = 4'd0;
                           result_valid   = 1'b1;
                           result.status  = mfr_pkg::ST_OK;
                           result.address = addr_ff;
                           result.payload = data_shifted;
                        end else begin
                           bidx_in  = bidx_inc;
                           phase_in = mfr_pkg::PH_DAT_WAIT;
                        end
                     end
                  endcase
               end
            end
            default: begin
               // idle: a rising edge arms the receiver
               phase_in = mfr_pkg::PH_IDLE;
               if (rx_level && !last_ff) begin
                  phase_in = mfr_pkg::PH_S1_HI;
                  tick_in  = '0;
               end
            end
         endcase
         if (result_valid) begin
            phase_in = mfr_pkg::PH_IDLE;
         end
      end
   end

   // state registers
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= mfr_pkg::PH_IDLE;
         tick_ff  <= '0;
         last_ff  <= 1'b0;
         early_ff <= 8'd0;
         late_ff  <= 9'd0;
         held_ff  <= 1'b0;
         bidx_ff  <= 4'd0;
         addr_ff  <= 8'd0;
         data_ff  <= 8'd0;
      end else begin
         phase_ff <= phase_in;
         tick_ff  <= tick_in;
         last_ff  <= last_in;
         early_ff <= early_in;
         late_ff  <= late_in;
         held_ff  <= held_in;
         bidx_ff  <= bidx_in;
         addr_ff  <= addr_in;
         data_ff  <= data_in;
      end
   end

endmodule

// ----- rtl/mfr_result_buffer.sv -----
module mfr_result_buffer (
   input  logic                clock,
   input  logic                reset,
   input  logic                push,
   input  mfr_pkg::result_type push_data,
   input  logic                pop,
   output logic                full,
   output logic                not_empty,
   output mfr_pkg::result_type head
);

   mfr_pkg::result_type mem_ff [2];
   logic                wr_ptr_ff, wr_ptr_in;
   logic                rd_ptr_ff, rd_ptr_in;
   logic [1:0]          count_ff, count_in;
   logic                do_pop;

   // two-entry queue between the decoder and the result channel
   always_comb begin
      do_pop    = pop && (count_ff != 2'd0);
      wr_ptr_in = push ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = do_pop ? ~rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff + {1'b0, push} - {1'b0, do_pop};
      full      = (count_ff == 2'd2);
      not_empty = (count_ff != 2'd0);
      head      = mem_ff[rd_ptr_ff];
   end

   // entry storage
   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end

   // pointers and fill count
   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

// ----- rtl/manchester_frame_receiver.sv -----
// channel   direction  handshake          payload
// req       in         req_valid/stall    req_rx_level
// rsp       out        rsp_valid/stall    rsp_status, rsp_address, rsp_payload
// csr       in         csr_valid/ready    csr_index, csr_data
//
// one sample transaction per cycle while req_stall is low; the decoder
// updates its state in the cycle it takes the sample, and a result sits in
// a two-entry queue from the next cycle on. reset is synchronous and
// returns the decoder to idle with default register values. req_stall is
// high whenever both queue entries are occupied. csr writes complete at once.
`include "manchester_frame_receiver_assert.svh"

module manchester_frame_receiver (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   input  logic       req_rx_level,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output logic [2:0] rsp_status,
   output logic [7:0] rsp_address,
   output logic [7:0] rsp_payload,
   input  logic       csr_valid,
   output logic       csr_ready,
   input  logic [1:0] csr_index,
   input  logic [6:0] csr_data
);

   mfr_pkg::cfg_type    cfg_ff, cfg_in;
   mfr_pkg::result_type result;
   mfr_pkg::result_type head;
   logic                result_valid;
   logic                accept;
   logic                full;
   logic                not_empty;

   // configuration registers
   always_comb begin
      csr_ready = 1'b1;
      cfg_in    = cfg_ff;
      if (csr_valid) begin
         case (mfr_pkg::csr_index_type'(csr_index))
            mfr_pkg::CSR_MIN_HALF: cfg_in.min_half = csr_data;
            mfr_pkg::CSR_MAX_HALF: cfg_in.max_half = csr_data;
            mfr_pkg::CSR_MAX_PRE:  cfg_in.max_pre  = csr_data[3:0];
            default:               cfg_in          = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.min_half <= mfr_pkg::MIN_HALF_RESET;
         cfg_ff.max_half <= mfr_pkg::MAX_HALF_RESET;
         cfg_ff.max_pre  <= mfr_pkg::MAX_PRE_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // sample transaction handshake
   assign req_stall = full;
   assign accept    = req_valid && !full;

   mfr_decoder u_decoder (
      .clock        (clock),
      .reset        (reset),
      .accept       (accept),
      .rx_level     (req_rx_level),
      .cfg          (cfg_ff),
      .result_valid (result_valid),
      .result       (result)
   );

   mfr_result_buffer u_buffer (
      .clock     (clock),
      .reset     (reset),
      .push      (result_valid),
      .push_data (result),
      .pop       (!rsp_stall),
      .full      (full),
      .not_empty (not_empty),
      .head      (head)
   );

   // result channel
   assign rsp_valid   = not_empty;
   assign rsp_status  = head.status;
   assign rsp_address = head.address;
   assign rsp_payload = head.payload;

   // checks
   `MFR_ASSERT_NOW(a_full_shows_result, clock, reset, req_stall, rsp_valid)
   `MFR_ASSERT_NOW(a_error_clears_fields, clock, reset,
      result_valid && (result.status != mfr_pkg::ST_OK),
      (result.address == 8'd0) && (result.payload == 8'd0))
   `MFR_ASSERT_NEXT(a_drain_frees_slot, clock, reset,
      rsp_valid && !rsp_stall && !result_valid, !req_stall)
   `MFR_ASSERT_NOW(a_result_needs_sample, clock, reset, result_valid, accept)

endmodule

// ----- sim/tb_manchester_frame_receiver.sv -----
module tb_manchester_frame_receiver;

   localparam int QUIET_LIMIT = 4000;

   // clock and reset
   logic clock = 1'b0;
   logic reset = 1'b1;
   always #1 clock = ~clock;

   // block ports
   logic       req_valid = 1'b0;
   logic       req_rx_level = 1'b0;
   logic       req_stall;
   logic       rsp_valid;
   logic       rsp_stall = 1'b0;
   logic [2:0] rsp_status;
   logic [7:0] rsp_address;
   logic [7:0] rsp_payload;
   logic       csr_valid = 1'b0;
   logic       csr_ready;
   logic [1:0] csr_index = 2'd0;
   logic [6:0] csr_data = 7'd0;

   manchester_frame_receiver uut (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_stall    (req_stall),
      .req_rx_level (req_rx_level),
      .rsp_valid    (rsp_valid),
      .rsp_stall    (rsp_stall),
      .rsp_status   (rsp_status),
      .rsp_address  (rsp_address),
      .rsp_payload  (rsp_payload),
      .csr_valid    (csr_valid),
      .csr_ready    (csr_ready),
      .csr_index    (csr_index),
      .csr_data     (csr_data)
   );

   // block outputs captured mid-cycle, used at the next rising edge
   logic       s_req_stall = 1'b0;
   logic       s_rsp_valid = 1'b0;
   logic [2:0] s_status = '0;
   logic [7:0] s_address = '0;
   logic [7:0] s_payload = '0;
   logic       s_csr_ready = 1'b0;

   always @(negedge clock) begin
      s_req_stall = req_stall;
      s_rsp_valid = rsp_valid;
      s_status    = rsp_status;
      s_address   = rsp_address;
      s_payload   = rsp_payload;
      s_csr_ready = csr_ready;
   end

   // line levels waiting to be sent, frames waiting to come back
   logic                level_q[$];
   mfr_pkg::result_type frames_due[$];
   mfr_pkg::result_type want_frame;

   // decoder copy kept by the testbench
   logic [6:0]         cfg_min = mfr_pkg::MIN_HALF_RESET;
   logic [6:0]         cfg_max = mfr_pkg::MAX_HALF_RESET;
   logic [3:0]         cfg_pre = mfr_pkg::MAX_PRE_RESET;
   mfr_pkg::phase_type rx_phase = mfr_pkg::PH_IDLE;
   mfr_pkg::tick_type  rx_tick = '0;
   logic               rx_last = 1'b0;
   logic [7:0]         rx_period = '0;
   logic [7:0]         rx_early = '0;
   logic [8:0]         rx_late = '0;
   logic               rx_held = 1'b0;
   logic [3:0]         rx_bits = '0;
   logic [7:0]         rx_adr = '0;
   logic [7:0]         rx_dat = '0;

   // run bookkeeping
   int  samples_taken = 0;
   int  results_made = 0;
   int  frames_checked = 0;
   int  frames_ok = 0;
   int  reg_writes = 0;
   int  failures = 0;
   int  quiet = 0;
   logic calm = 1'b0;

   function automatic bit tick_expired(int limit);
      return (int'(rx_tick) > limit) || (rx_tick == mfr_pkg::TICK_MAX);
   endfunction

   // end of a frame attempt: queue the expected result, back to idle
   task close_frame(input mfr_pkg::status_type st);
      mfr_pkg::result_type r;
      r.status  = st;
      r.address = (st == mfr_pkg::ST_OK) ? rx_adr : 8'h00;
      r.payload = (st == mfr_pkg::ST_OK) ? rx_dat : 8'h00;
      frames_due.push_back(r);
      results_made++;
      rx_phase = mfr_pkg::PH_IDLE;
   endtask

   // advance the decoder copy by one sampled line level
   task decode_sample(input logic lvl);
      logic prev;
      logic bit_val;
      prev = rx_last;
      rx_last = lvl;
      if (rx_phase == mfr_pkg::PH_IDLE) begin
         if (lvl && !prev) begin
            rx_phase = mfr_pkg::PH_S1_HI;
            rx_tick = '0;
         end
         return;
      end
      if (rx_tick != mfr_pkg::TICK_MAX) rx_tick = rx_tick + 1'b1;
      case (rx_phase)
         mfr_pkg::PH_S1_HI: begin
            if (!lvl) begin
               rx_tick = '0;
               rx_phase = mfr_pkg::PH_S2_LO;
            end else if (tick_expired(cfg_max)) close_frame(mfr_pkg::ST_SYNC_TMO);
         end
         mfr_pkg::PH_S2_LO: begin
            if (lvl) rx_phase = mfr_pkg::PH_S2_HI;
            else if (tick_expired(cfg_max)) close_frame(mfr_pkg::ST_SYNC_TMO);
         end
         mfr_pkg::PH_S2_HI: begin
            if (!lvl) begin
               rx_tick = '0;
               rx_phase = mfr_pkg::PH_S3_LO;
            end else if (tick_expired(2 * int'(cfg_max))) close_frame(mfr_pkg::ST_SYNC_TMO);
         end
         mfr_pkg::PH_S3_LO: begin
            if (lvl) rx_phase = mfr_pkg::PH_S3_HI;
            else if (tick_expired(cfg_max)) close_frame(mfr_pkg::ST_SYNC_TMO);
         end
         mfr_pkg::PH_S3_HI: begin
            // full symbol measured here, sets the sample windows
            if (!lvl) begin
               rx_period = rx_tick[7:0];
               rx_tick = '0;
               if (int'(rx_period) < 2 * int'(cfg_min) ||
                   int'(rx_period) > 2 * int'(cfg_max))
                  close_frame(mfr_pkg::ST_PERIOD_ERR);
               else begin
                  rx_early = rx_period - (rx_period >> 2);
                  rx_late = {1'b0, rx_period} + {3'b000, rx_period[7:2]};
                  rx_phase = mfr_pkg::PH_S4_LO;
               end
            end else if (tick_expired(2 * int'(cfg_max))) close_frame(mfr_pkg::ST_SYNC_TMO);
         end
         mfr_pkg::PH_S4_LO: begin
            if (lvl) begin
               rx_tick = '0;
               rx_bits = '0;
               rx_phase = mfr_pkg::PH_PRE_WAIT;
            end else if (tick_expired(cfg_max)) close_frame(mfr_pkg::ST_SYNC_TMO);
         end
         mfr_pkg::PH_PRE_WAIT, mfr_pkg::PH_ADR_WAIT, mfr_pkg::PH_DAT_WAIT: begin
            if (rx_tick >= rx_early) begin
               rx_held = lvl;
               rx_phase = mfr_pkg::phase_type'(rx_phase + 4'd1);
            end
         end
         default: begin
            // mid-symbol edge phases
            if (lvl == rx_held) begin
               if (tick_expired(rx_late)) close_frame(mfr_pkg::ST_BIT_TIMING);
            end else begin
               bit_val = !rx_held;
               rx_tick = '0;
               case (rx_phase)
                  mfr_pkg::PH_PRE_EDGE: begin
                     if (!bit_val) begin
                        rx_bits = '0;
                        rx_adr = '0;
                        rx_phase = mfr_pkg::PH_ADR_WAIT;
                     end else if (int'(rx_bits) + 1 > int'(cfg_pre)) begin
                        close_frame(mfr_pkg::ST_PREAMBLE);
                     end else begin
                        rx_bits = rx_bits + 1'b1;
                        rx_phase = mfr_pkg::PH_PRE_WAIT;
                     end
                  end
                  mfr_pkg::PH_ADR_EDGE: begin
                     rx_adr = {rx_adr[6:0], bit_val};
                     rx_bits = rx_bits + 1'b1;
                     if (rx_bits >= 4'd8) begin
                        rx_bits = '0;
                        rx_dat = '0;
                        rx_phase = mfr_pkg::PH_DAT_WAIT;
                     end else rx_phase = mfr_pkg::PH_ADR_WAIT;
                  end
                  default: begin
                     rx_dat = {rx_dat[6:0], bit_val};
                     rx_bits = rx_bits + 1'b1;
                     if (rx_bits >= 4'd8) begin
                        rx_bits = '0;
                        close_frame(mfr_pkg::ST_OK);
                     end else rx_phase = mfr_pkg::PH_DAT_WAIT;
                  end
               endcase
            end
         end
      endcase
   endtask

   // sample driver
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && !s_req_stall) begin
            decode_sample(req_rx_level);
            samples_taken++;
         end
         if (!req_valid || !s_req_stall) begin
            if (level_q.size() != 0 && (calm || $urandom_range(99, 0) >= 17)) begin
               req_valid <= 1'b1;
               req_rx_level <= level_q.pop_front();
            end else req_valid <= 1'b0;
         end
      end
   end

   // result monitor and receiver stalls
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (s_rsp_valid && !rsp_stall) begin
            frames_checked++;
            if (frames_due.size() == 0) begin
               $display("%0t: result with none expected: status %0d address %02h payload %02h",
                        $time, s_status, s_address, s_payload);
               failures++;
            end else begin
               want_frame = frames_due.pop_front();
               if (s_status !== want_frame.status) begin
                  $display("%0t: status mismatch, expected %0d actual %0d",
                           $time, want_frame.status, s_status);
                  failures++;
               end
               if (s_address !== want_frame.address) begin
                  $display("%0t: address mismatch, expected %02h actual %02h",
                           $time, want_frame.address, s_address);
                  failures++;
               end
               if (s_payload !== want_frame.payload) begin
                  $display("%0t: payload mismatch, expected %02h actual %02h",
                           $time, want_frame.payload, s_payload);
                  failures++;
               end
               if (want_frame.status == mfr_pkg::ST_OK) frames_ok++;
            end
         end
         rsp_stall <= !calm && ($urandom_range(99, 0) < 17);
      end
   end

   // watchdog on cycles without any transaction
   wire progress = (req_valid && !s_req_stall) || (s_rsp_valid && !rsp_stall) ||
                   (csr_valid && s_csr_ready);

   always @(posedge clock) begin
      if (reset || progress) quiet <= 0;
      else quiet <= quiet + 1;
      if (quiet >= QUIET_LIMIT) begin
         $display("%0t: no transaction for %0d cycles", $time, quiet);
         $display("TEST FAILED");
         $finish;
      end
   end

   // register write, applied to the decoder copy on the handshake
   task automatic write_reg(input mfr_pkg::csr_index_type idx, input logic [6:0] val);
      @(posedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= val;
      @(posedge clock);
      while (!s_csr_ready) @(posedge clock);
      case (idx)
         mfr_pkg::CSR_MIN_HALF: cfg_min = val;
         mfr_pkg::CSR_MAX_HALF: cfg_max = val;
         mfr_pkg::CSR_MAX_PRE:  cfg_pre = val[3:0];
         default: ;
      endcase
      reg_writes++;
      csr_valid <= 1'b0;
   endtask

   task automatic set_limits(input int mn, input int mx, input int pre);
      write_reg(mfr_pkg::CSR_MIN_HALF, mn[6:0]);
      write_reg(mfr_pkg::CSR_MAX_HALF, mx[6:0]);
      write_reg(mfr_pkg::CSR_MAX_PRE, {3'b000, pre[3:0]});
   endtask

   // hold the sender until every expected frame is back, then let the block go quiet
   task automatic settle();
      while (level_q.size() != 0 || req_valid) @(negedge clock);
      while (frames_due.size() != 0) @(negedge clock);
      repeat (8) @(posedge clock);
   endtask

   // one frame as line levels: sync, preamble ones, start zero, address, data;
   // a nonzero cut stops after that many half symbols and holds the line
   task automatic queue_frame(input int h, input int ones, input logic [7:0] adr,
                              input logic [7:0] dat, input bit jitter, input int cut);
      logic        halves[$];
      logic [15:0] word;
      int          n;
      int          last;
      halves = '{1'b1, 1'b0, 1'b1, 1'b0, 1'b1, 1'b0, 1'b1};
      repeat (ones) begin
         halves.push_back(1'b0);
         halves.push_back(1'b1);
      end
      halves.push_back(1'b1);
      halves.push_back(1'b0);
      word = {adr, dat};
      for (int i = 15; i >= 0; i--) begin
         halves.push_back(!word[i]);
         halves.push_back(word[i]);
      end
      repeat ($urandom_range(4, 1)) level_q.push_back(1'b0);
      last = (cut > 0 && cut < halves.size()) ? cut : halves.size();
      for (int i = 0; i < last; i++) begin
         n = h;
         if (jitter && $urandom_range(3, 0) == 0) n = h + $urandom_range(2, 0) - 1;
         if (n < 1) n = 1;
         repeat (n) level_q.push_back(halves[i]);
      end
      if (cut > 0) repeat (2 * int'(cfg_max) + 6 * h + 8) level_q.push_back(halves[last - 1]);
   endtask

   // one random round: mostly clean frames, some broken frames and line noise
   task automatic random_round();
      int pick;
      int h;
      int hlo;
      int hhi;
      int ones;
      int total;
      hlo = (cfg_min < 2) ? 2 : int'(cfg_min);
      hhi = (cfg_max > 6) ? 6 : int'(cfg_max);
      if (hlo > hhi) begin
         hlo = 2;
         hhi = 5;
      end
      h = $urandom_range(hhi, hlo);
      if ($urandom_range(9, 0) == 0) h = $urandom_range(1, 0) ? hhi + 1 : ((hlo > 1) ? hlo - 1 : 1);
      pick = $urandom_range(99, 0);
      if (pick < 70) begin
         ones = $urandom_range(int'(cfg_pre), 0);
         queue_frame(h, ones, 8'($urandom_range(255, 0)), 8'($urandom_range(255, 0)),
                     (h >= 4) && ($urandom_range(4, 0) == 0), 0);
      end else if (pick < 85) begin
         ones = $urandom_range(int'(cfg_pre) + 2, 0);
         total = 7 + 2 * (ones + 17);
         queue_frame(h, ones, 8'($urandom_range(255, 0)), 8'($urandom_range(255, 0)),
                     1'b0, $urandom_range(total - 1, 1));
      end else begin
         repeat ($urandom_range(30, 3)) level_q.push_back(1'($urandom_range(1, 0)));
      end
   endtask

   task automatic run_phase(input int min_samples, input int min_results);
      int samples0;
      int results0;
      @(negedge clock);
      samples0 = samples_taken;
      results0 = results_made;
      while (samples_taken - samples0 < min_samples || results_made - results0 < min_results)
      begin
         while (level_q.size() > 16) @(negedge clock);
         random_round();
      end
      settle();
   endtask

   // stimulus sequence
   initial begin
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // register defaults: a short symbol below the minimum period, then a
      // sync high held past the maximum half period
      repeat (2) level_q.push_back(1'b0);
      repeat (3) begin
         repeat (2) level_q.push_back(1'b1);
         repeat (2) level_q.push_back(1'b0);
      end
      repeat (72) level_q.push_back(1'b1);
      repeat (2) level_q.push_back(1'b0);
      settle();

      // directed frames around a narrow window; unused register index ignored
      set_limits(2, 6, 3);
      write_reg(mfr_pkg::CSR_UNUSED, 7'h7F);
      @(negedge clock);
      queue_frame(3, 2, 8'h5A, 8'hA5, 1'b0, 0);
      queue_frame(2, 4, 8'h81, 8'h7E, 1'b0, 0);
      queue_frame(1, 0, 8'h11, 8'h22, 1'b0, 0);
      queue_frame(7, 0, 8'h33, 8'h44, 1'b0, 6);
      queue_frame(3, 0, 8'h12, 8'h34, 1'b0, 10);
      settle();

      // zero minimum, short preamble, no idling on either side
      set_limits(0, 4, 2);
      calm <= 1'b1;
      run_phase(120, 1);
      calm <= 1'b0;

      // minimum above a zero maximum: only error outcomes
      set_limits(127, 0, 0);
      run_phase(30, 1);

      $display("covered %0d line samples under %0d register writes", samples_taken, reg_writes);
      $display("checked %0d frame results, %0d decoded clean and the rest error outcomes",
               frames_checked, frames_ok);
      if (frames_due.size() != 0)
         $display("%0t: %0d expected results never arrived", $time, frames_due.size());
      if (failures == 0 && frames_due.size() == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

endmodule

// ----- manchester_frame_receiver.f -----
+incdir+rtl
rtl/mfr_pkg.sv
rtl/mfr_decoder.sv
rtl/mfr_result_buffer.sv
rtl/manchester_frame_receiver.sv
sim/tb_manchester_frame_receiver.sv
